// File: rtl/mnpg_pkg.sv
// Package for the monophonic last-note-priority front end.
// Holds the request opcodes, register indexes, sequencer states and reset constants.
// No dependencies.
package mnpg_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GLIDE     = 2'd0,
        REG_TRANSPOSE = 2'd1,
        REG_TRIG_LEN  = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH,
        ST_TICK
    } state_t;

    localparam logic [6:0]  RESET_NOTE     = 7'd60;
    localparam logic [15:0] RESET_TRIG_LEN = 16'd48;

endpackage

// File: rtl/mono_note_priority_glide.sv
// Monophonic last-note-priority keyboard front end with one-pole glide.
// Tick: busy during ST_TICK, then the registered result strobes; the next tick waits for idle.
// Note-off walks the held-note memory one entry per cycle, busy throughout the walk;
// note-on adds a push step (ST_PUSH), and on a full stack a second pass drops the
// oldest note. All-notes-off does not raise busy. No result stalls.
// Reset (rst_n low, asynchronous) empties the stack and restores register defaults.
module mono_note_priority_glide
    import mnpg_pkg::*;
#(
    parameter int MAX_HELD = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [6:0]         note,
    input  logic [15:0]        strike_velocity,
    // configuration write port
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    // result channel
    output logic               strobe,
    output logic signed [16:0] pitch,
    output logic               gate,
    output logic [15:0]        level,
    output logic               trigger
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HELD);

    // Held-note memory
    logic [6:0] mem [0:MAX_HELD-1];

    state_t state_reg, state_next;

    logic [15:0]   coef_reg, transpose_reg, trig_len_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          dv_reg, dv_next;
    logic [6:0]    rd_data_reg;
    logic [6:0]    last_reg, last_next;
    logic          pass2_reg, pass2_next;
    op_t           op_reg, op_next;
    logic [6:0]    note_reg, note_next;
    logic          gate_reg, gate_next;
    logic [15:0]   vel_reg, vel_next;
    logic [6:0]    target_reg, target_next;
    logic [22:0]   glide_reg, glide_next;
    logic [15:0]   pulse_reg, pulse_next;
    logic signed [40:0] prod_reg;

    logic signed [16:0] pitch_reg, pitch_next;
    logic               gate_out_reg, gate_out_next;
    logic [15:0]        level_reg, level_next;
    logic               trigger_reg, trigger_next;
    logic               strobe_reg, strobe_next;

    logic          accept;
    op_t           op_in;
    logic          issue;
    logic          keep;
    logic          scan_done;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [6:0]    mem_wdata;

    logic signed [23:0] diff;
    logic signed [40:0] prod;
    logic signed [40:0] biased;
    logic signed [24:0] step_r;
    logic [24:0]        glide_sum;
    logic [23:0]        rounded;

    assign op_in     = op_t'(op);
    assign accept    = start && (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_SCAN) && (rd_ptr_reg < cnt_reg);
    assign keep      = dv_reg && (rd_data_reg != note_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !dv_reg;

    // Glide multiply: distance to target times retention
    assign diff = $signed({1'b0, glide_reg}) - $signed({1'b0, target_reg, 16'd0});
    assign prod = 41'(diff) * $signed({25'd0, coef_reg});

    // Round and rebuild the glided pitch from the registered product
    assign biased    = prod_reg + 41'sd32768;
    assign step_r    = biased[40:16];
    assign glide_sum = {2'b00, target_reg, 16'd0} + 25'(step_r);
    assign rounded   = {1'b0, glide_sum[22:0]} + 24'd128;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_NOTE_ON:  state_next = ST_SCAN;
                        OP_NOTE_OFF: state_next = ST_SCAN;
                        OP_TICK:     state_next = ST_TICK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (op_reg == OP_NOTE_ON)
                    begin
                        if (!((wr_ptr_reg == MAX_CNT) && !pass2_reg))
                        begin
                            state_next = ST_PUSH;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PUSH: state_next = ST_IDLE;
            ST_TICK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        dv_next       = 1'b0;
        last_next     = last_reg;
        pass2_next    = pass2_reg;
        op_next       = op_reg;
        note_next     = note_reg;
        gate_next     = gate_reg;
        vel_next      = vel_reg;
        target_next   = target_reg;
        glide_next    = glide_reg;
        pulse_next    = pulse_reg;
        pitch_next    = pitch_reg;
        gate_out_next = gate_out_reg;
        level_next    = level_reg;
        trigger_next  = trigger_reg;
        strobe_next   = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = wr_ptr_reg[AW-1:0];
        mem_wdata     = rd_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_in;
                    note_next   = note;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    pass2_next  = 1'b0;
                    case (op_in)
                        OP_NOTE_ON:
                        begin
                            vel_next   = strike_velocity;
                            gate_next  = 1'b1;
                            pulse_next = (trig_len_reg > 16'd1) ? trig_len_reg : 16'd1;
                        end
                        OP_ALL_OFF:
                        begin
                            cnt_next  = '0;
                            gate_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // advance the read pointer, compact kept entries down
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    dv_next     = 1'b1;
                end
                if (keep)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                    last_next   = rd_data_reg;
                end
                if (scan_done)
                begin
                    if (op_reg == OP_NOTE_ON)
                    begin
                        // full stack: drop the oldest entry in a second pass
                        if ((wr_ptr_reg == MAX_CNT) && !pass2_reg)
                        begin
                            cnt_next    = wr_ptr_reg;
                            rd_ptr_next = CW'(1);
                            wr_ptr_next = '0;
                            pass2_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = wr_ptr_reg;
                        if (wr_ptr_reg == '0)
                        begin
                            gate_next = 1'b0;
                        end
                        else
                        begin
                            target_next = last_reg;
                        end
                    end
                end
            end
            ST_PUSH:
            begin
                mem_we      = 1'b1;
                mem_wdata   = note_reg;
                cnt_next    = wr_ptr_reg + 1'b1;
                target_next = note_reg;
            end
            ST_TICK:
            begin
                glide_next    = glide_sum[22:0];
                pitch_next    = $signed({1'b0, rounded[23:8]})
                              + $signed({transpose_reg[15], transpose_reg});
                gate_out_next = gate_reg;
                level_next    = vel_reg;
                trigger_next  = (pulse_reg != 16'd0);
                strobe_next   = 1'b1;
                if (pulse_reg != 16'd0)
                begin
                    pulse_next = pulse_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // Glide product register
    always_ff @(posedge clk)
    begin
        if (accept && (op_in == OP_TICK))
        begin
            prod_reg <= prod;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        note_reg    <= note_next;
        pitch_reg   <= pitch_next;
        level_reg   <= level_next;
        gate_out_reg <= gate_out_next;
        trigger_reg <= trigger_next;
    end

    // Control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            pass2_reg     <= 1'b0;
            gate_reg      <= 1'b0;
            vel_reg       <= '0;
            target_reg    <= RESET_NOTE;
            glide_reg     <= {RESET_NOTE, 16'd0};
            pulse_reg     <= '0;
            strobe_reg    <= 1'b0;
            coef_reg      <= '0;
            transpose_reg <= '0;
            trig_len_reg  <= RESET_TRIG_LEN;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            dv_reg     <= dv_next;
            pass2_reg  <= pass2_next;
            gate_reg   <= gate_next;
            vel_reg    <= vel_next;
            target_reg <= target_next;
            glide_reg  <= glide_next;
            pulse_reg  <= pulse_next;
            strobe_reg <= strobe_next;
            // configuration writes
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_GLIDE:     coef_reg      <= wr_data;
                    REG_TRANSPOSE: transpose_reg <= wr_data;
                    REG_TRIG_LEN:  trig_len_reg  <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign strobe  = strobe_reg;
    assign pitch   = pitch_reg;
    assign gate    = gate_out_reg;
    assign level   = level_reg;
    assign trigger = trigger_reg;

endmodule

// File: rtl/mnpg_checker.sv
// Port-level checker for the monophonic note front end, bound to the top level.
// Depends on mnpg_pkg for the request opcodes.
module mnpg_checker
    import mnpg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] op,
    input logic       strobe
);

    // A tick request yields a result once it passes ST_TICK and the strobe register
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_TICK)) |-> ##2 strobe)
        else $error("tick request produced no result");

    // A result only follows a tick request
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && (op == OP_TICK), 2))
        else $error("result without a tick request");

    // The block is idle again when the result shows
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("busy while a result is shown");

    // A result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held longer than one cycle");

endmodule

bind mono_note_priority_glide mnpg_checker u_mnpg_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .strobe (strobe)
);

// File: dv/mono_note_priority_glide_test.sv
// Self-checking testbench for the mono_note_priority_glide keyboard front end.
// Drives note events and ticks, predicts each tick result and compares field by field.
// Depends on rtl/mnpg_pkg.sv and rtl/mono_note_priority_glide.sv.
module mono_note_priority_glide_test;
    import mnpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 16;
    localparam int SETTLE_WAIT  = 40;      // longer than the slowest note event
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 6;

    typedef struct {
        op_t         op;
        logic [6:0]  note;
        logic [15:0] velocity;
    } key_request_t;

    typedef struct {
        logic signed [16:0] pitch;
        logic               gate;
        logic [15:0]        level;
        logic               trigger;
    } tick_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         op = OP_TICK;
    logic [6:0]         note = '0;
    logic [15:0]        strike_velocity = '0;
    logic               wr_en = 1'b0;
    logic [1:0]         wr_index = REG_GLIDE;
    logic [15:0]        wr_data = '0;
    logic               strobe;
    logic signed [16:0] pitch;
    logic               gate;
    logic [15:0]        level;
    logic               trigger;

    key_request_t pending_requests[$];
    tick_result_t expected_ticks[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;

    // Predictor state: configuration and keyboard state
    logic [15:0] glide_coef;
    logic [15:0] transpose_q88;
    logic [15:0] pulse_length;
    logic [6:0]  held_notes[$];
    logic        gate_held;
    logic [15:0] velocity_latch;
    logic [6:0]  target_note;
    logic [22:0] glide_q716;
    logic [15:0] pulse_count;

    // Sender burst pacing
    int  burst_left = 1;
    int  gap_left = 0;
    bit  steady = 1'b0;

    mono_note_priority_glide dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .note            (note),
        .strike_velocity (strike_velocity),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .strobe          (strobe),
        .pitch           (pitch),
        .gate            (gate),
        .level           (level),
        .trigger         (trigger)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one accepted request to the predictor; ticks queue one result
    task automatic predict_request(op_t kind, logic [6:0] key, logic [15:0] vel);
        longint       tgt;
        longint       delta;
        longint       step;
        longint       sum;
        tick_result_t res;
        if (kind == OP_TICK)
        begin
            tgt        = longint'(target_note) <<< 16;
            delta      = longint'(glide_q716) - tgt;
            step       = (delta * longint'(glide_coef) + 32768) >>> 16;
            glide_q716 = 23'(tgt + step);
            sum        = ((longint'(glide_q716) + 128) >>> 8) + longint'($signed(transpose_q88));
            res.pitch   = 17'(sum);
            res.gate    = gate_held;
            res.level   = velocity_latch;
            res.trigger = (pulse_count != 0);
            if (pulse_count != 0)
                pulse_count = pulse_count - 1;
            expected_ticks.push_back(res);
            return;
        end
        if (kind == OP_NOTE_ON || kind == OP_NOTE_OFF)
        begin
            for (int i = held_notes.size() - 1; i >= 0; i--)
                if (held_notes[i] == key)
                    held_notes.delete(i);
        end
        case (kind)
            OP_NOTE_ON:
            begin
                if (held_notes.size() >= STACK_DEPTH)
                    void'(held_notes.pop_front());
                held_notes.push_back(key);
                velocity_latch = vel;
                gate_held      = 1'b1;
                pulse_count    = (pulse_length > 1) ? pulse_length : 16'd1;
            end
            OP_NOTE_OFF:
            begin
                if (held_notes.size() == 0)
                    gate_held = 1'b0;
            end
            default:
            begin
                held_notes.delete();
                gate_held = 1'b0;
            end
        endcase
        // Hold the previous target while the stack is empty
        if (held_notes.size() > 0)
            target_note = held_notes[held_notes.size() - 1];
    endtask

    // Driver: present queued requests in bursts with random gaps, gapless in steady phases
    always @(posedge clk)
    begin
        key_request_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                predict_request(op_t'(op), note, strike_velocity);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    op              <= req.op;
                    note            <= req.note;
                    strike_velocity <= req.velocity;
                    start           <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        if (steady)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(10, 45);
                        else
                            gap_left = $urandom_range(0, 5);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && strobe)
        begin
            if (expected_ticks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: pitch=%0d gate=%0b level=%h trigger=%0b",
                             pitch, gate, level, trigger);
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (pitch !== want.pitch || gate !== want.gate ||
                    level !== want.level || trigger !== want.trigger)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tick mismatch: exp pitch=%0d gate=%0b level=%h trigger=%0b, got pitch=%0d gate=%0b level=%h trigger=%0b",
                                 want.pitch, want.gate, want.level, want.trigger,
                                 pitch, gate, level, trigger);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void push_request(op_t kind, int key, int vel);
        key_request_t req;
        req.op       = kind;
        req.note     = 7'(key);
        req.velocity = 16'(vel);
        pending_requests.push_back(req);
    endfunction

    // Write one register; caller is at a clock edge and lowers wr_en afterwards
    task automatic write_register(reg_idx_t idx, logic [15:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        case (idx)
            REG_GLIDE:     glide_coef    = value;
            REG_TRANSPOSE: transpose_q88 = value;
            REG_TRIG_LEN:  pulse_length  = value;
            default:       ;
        endcase
    endtask

    // Wait until every request is taken and every result is back, then let busy drain
    task automatic settle();
        while (pending_requests.size() != 0 || start || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Random playing: a full-stack chord first, then phrases of notes and tick runs
    task automatic queue_phrases(int total);
        int made;
        int base;
        int span;
        int pick;
        int key;
        int run;
        int recent[$];
        made = 0;
        base = $urandom_range(0, 107);
        span = $urandom_range(17, 20);
        for (int i = 0; i < span; i++)
        begin
            push_request(OP_NOTE_ON, base + i, $urandom);
            recent.push_back(base + i);
        end
        made = span;
        while (made < total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if ($urandom_range(0, 3) == 0)
                    key = $urandom_range(0, 127);
                else
                    key = (base + $urandom_range(0, 20)) % 128;
                push_request(OP_NOTE_ON, key, $urandom);
                recent.push_back(key);
                if (recent.size() > STACK_DEPTH)
                    void'(recent.pop_front());
                made++;
            end
            else if (pick < 50)
            begin
                if (recent.size() > 0 && $urandom_range(0, 4) != 0)
                begin
                    run = $urandom_range(0, recent.size() - 1);
                    key = recent[run];
                    recent.delete(run);
                end
                else
                    key = $urandom_range(0, 127);
                push_request(OP_NOTE_OFF, key, $urandom);
                made++;
            end
            else if (pick < 53)
            begin
                push_request(OP_ALL_OFF, $urandom, $urandom);
                recent.delete();
                made++;
            end
            else
            begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
                for (int i = 0; i < run; i++)
                    push_request(OP_TICK, $urandom, $urandom);
                made += run;
            end
        end
    endtask

    initial
    begin
        logic [15:0] glide_set[NUM_PHASES];
        logic [15:0] transpose_set[NUM_PHASES];
        logic [15:0] length_set[NUM_PHASES];

        glide_coef     = '0;
        transpose_q88  = '0;
        pulse_length   = RESET_TRIG_LEN;
        held_notes.delete();
        gate_held      = 1'b0;
        velocity_latch = '0;
        target_note    = RESET_NOTE;
        glide_q716     = {RESET_NOTE, 16'h0000};
        pulse_count    = '0;

        glide_set     = '{16'hFFFF, 16'h8000, 16'($urandom), 16'hF000, 16'h0000, 16'($urandom)};
        transpose_set = '{16'h6000, 16'hA000, 16'($urandom), 16'h7FFF, 16'h8000, 16'h0000};
        length_set    = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 6)), 16'd3, 16'd48};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, duplicates, stray note-offs, empty stack, all-notes-off
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_ON, 127, 16'hFFFF);
        push_request(OP_TICK, 127, 16'hFFFF);
        push_request(OP_NOTE_ON, 0, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_ON, 0, 16'h8000);
        push_request(OP_NOTE_OFF, 0, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_OFF, 5, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_OFF, 127, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_OFF, 3, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_ON, 64, 1);
        push_request(OP_NOTE_ON, 65, 2);
        push_request(OP_ALL_OFF, 0, 0);
        push_request(OP_TICK, 0, 0);
        push_request(OP_NOTE_ON, 85, 16'hAAAA);
        push_request(OP_TICK, 42, 16'h5555);
        push_request(OP_TICK, 0, 0);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_register(REG_GLIDE, glide_set[ph]);
            write_register(REG_TRANSPOSE, transpose_set[ph]);
            write_register(REG_TRIG_LEN, length_set[ph]);
            if (ph == 1)
                write_register(REG_NONE, 16'($urandom));
            wr_en <= 1'b0;
            steady = (ph % 3 == 1);
            queue_phrases(PHASE_ITEMS);
            settle();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mnpg_pkg.sv
rtl/mono_note_priority_glide.sv
rtl/mnpg_checker.sv
dv/mono_note_priority_glide_test.sv
